@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file kvfe_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ hw/rtl/kvfe_pkg.sv @@
// Package for the key/value field extractor: sizes, codes and constants.
`timescale 1ns / 1ps
`default_nettype none
package kvfe_pkg;

   localparam int KEY_MAX_BYTES = 8;
   localparam int WIN_BYTES     = (KEY_MAX_BYTES < 8) ? KEY_MAX_BYTES : 8;
   localparam int WIN_BITS      = 8 * WIN_BYTES;
   localparam int LEN_W         = $clog2(WIN_BYTES + 1);

   localparam logic [7:0] CLOSE_BRACE = 8'h7D;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_BYTES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DELIMITER  = 2'd2;

   localparam logic [1:0] PH_SEARCH = 2'd0;
   localparam logic [1:0] PH_SEP    = 2'd1;
   localparam logic [1:0] PH_VALUE  = 2'd2;

   localparam logic [1:0] ST_NONE     = 2'd0;
   localparam logic [1:0] ST_DELIM    = 2'd1;
   localparam logic [1:0] ST_CUT      = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   localparam logic [7:0]  DELIM_RESET   = 8'd44;
   localparam logic [3:0]  KEYLEN_RESET  = 4'd1;

endpackage
`default_nettype wire

@@ hw/rtl/kvfe_match.sv @@
// Parallel compare of the byte window against the key for the active key length.
`timescale 1ns / 1ps
`default_nettype none
module kvfe_match
   import kvfe_pkg::*;
(
   input  wire logic [WIN_BITS-1:0] window,
   input  wire logic [LEN_W-1:0]    fill,
   input  wire logic [63:0]         key_bytes,
   input  wire logic [LEN_W-1:0]    key_len,
   output logic                     match
);

   logic [WIN_BYTES:1] len_ok;

   // Newest byte is lowest; key byte k pairs with window byte L-1-k.
   always_comb begin
      for (int l = 1; l <= WIN_BYTES; l++) begin
         len_ok[l] = (fill >= LEN_W'(l));
         for (int k = 0; k < l; k++) begin
            if (window[8*(l-1-k) +: 8] != key_bytes[8*k +: 8]) begin
               len_ok[l] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      match = 1'b0;
      for (int l = 1; l <= WIN_BYTES; l++) begin
         if (key_len == LEN_W'(l)) begin
            match = len_ok[l];
         end
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/key_value_field_extractor_core.sv @@
// Top level of the key/value field extractor: control, CSRs and result register.
`timescale 1ns / 1ps
`default_nettype none
// Streams a text buffer one byte per item and emits the value bytes that follow
// each occurrence of the configured key (up to eight bytes, first byte in the low
// byte of key_bytes). After a key match the next byte is dropped as separator,
// then bytes pass out until the delimiter or '}', which is reported with
// end_status 1. The item flagged buffer_end resets the search; it reports 3 if
// no value was open and 2 if it cut a value short. Each item is handled by the window
// compare between the accept edge and the result register, so one item is taken per
// cycle whenever the result register is empty or being read. CSRs are to be written by
// the user through the csr_ port only while the block is idle; the block does not enforce it.
module key_value_field_extractor_core
   import kvfe_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]          csr_data,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_text_byte,
   input  wire logic                 req_buffer_end,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [7:0]                rsp_value_byte,
   output logic                      rsp_byte_valid,
   output logic                      rsp_value_end,
   output logic [1:0]                rsp_end_status
);

   logic [63:0]         key_bytes_ff;
   logic [3:0]          key_length_ff;
   logic [7:0]          delimiter_ff;

   logic [WIN_BITS-1:0] win_ff, win_in, win_shift;
   logic [LEN_W-1:0]    fill_ff, fill_in, fill_inc;
   logic [1:0]          phase_ff, phase_in;
   logic [LEN_W-1:0]    key_len;
   logic                match;

   logic                res_valid_ff, res_valid_in;
   logic [7:0]          res_byte_ff, res_byte_in;
   logic                res_bvalid_ff, res_bvalid_in;
   logic                res_end_ff, res_end_in;
   logic [1:0]          res_status_ff, res_status_in;

   logic                accept;
   logic                emit;

   assign csr_ready = 1'b1;
   assign req_ready = !res_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_bytes_ff  <= '0;
         key_length_ff <= KEYLEN_RESET;
         delimiter_ff  <= DELIM_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_KEY_BYTES:  key_bytes_ff  <= csr_data;
            REG_KEY_LENGTH: key_length_ff <= csr_data[3:0];
            REG_DELIMITER:  delimiter_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Zero counts as one, long keys saturate to the window.
   always_comb begin
      if (key_length_ff == 4'd0) begin
         key_len = LEN_W'(1);
      end else if (key_length_ff > 4'(WIN_BYTES)) begin
         key_len = LEN_W'(WIN_BYTES);
      end else begin
         key_len = key_length_ff[LEN_W-1:0];
      end
   end

   assign win_shift = (win_ff << 8) | WIN_BITS'(req_text_byte);
   assign fill_inc  = (fill_ff < LEN_W'(WIN_BYTES)) ? fill_ff + LEN_W'(1) : fill_ff;

   kvfe_match u_match (
      .window    (win_shift),
      .fill      (fill_inc),
      .key_bytes (key_bytes_ff),
      .key_len   (key_len),
      .match     (match)
   );

   always_comb begin
      win_in        = win_ff;
      fill_in       = fill_ff;
      phase_in      = phase_ff;
      emit          = 1'b0;
      res_byte_in   = 8'd0;
      res_bvalid_in = 1'b0;
      res_end_in    = 1'b0;
      res_status_in = ST_NONE;
      if (accept) begin
         case (phase_ff)
            PH_SEP: begin
               if (req_buffer_end) begin
                  win_in        = '0;
                  fill_in       = '0;
                  phase_in      = PH_SEARCH;
                  emit          = 1'b1;
                  res_end_in    = 1'b1;
                  res_status_in = ST_CUT;
               end else begin
                  phase_in = PH_VALUE;
               end
            end
            PH_VALUE: begin
               emit = 1'b1;
               if (req_text_byte == delimiter_ff || req_text_byte == CLOSE_BRACE) begin
                  win_in        = '0;
                  fill_in       = '0;
                  phase_in      = PH_SEARCH;
                  res_end_in    = 1'b1;
                  res_status_in = ST_DELIM;
               end else begin
                  res_byte_in   = req_text_byte;
                  res_bvalid_in = 1'b1;
                  if (req_buffer_end) begin
                     win_in        = '0;
                     fill_in       = '0;
                     phase_in      = PH_SEARCH;
                     res_end_in    = 1'b1;
                     res_status_in = ST_CUT;
                  end
               end
            end
            default: begin
               win_in  = win_shift;
               fill_in = fill_inc;
               if (req_buffer_end) begin
                  win_in        = '0;
                  fill_in       = '0;
                  phase_in      = PH_SEARCH;
                  emit          = 1'b1;
                  res_end_in    = 1'b1;
                  res_status_in = ST_NOTFOUND;
               end else if (match) begin
                  win_in   = '0;
                  fill_in  = '0;
                  phase_in = PH_SEP;
               end
            end
         endcase
      end
   end

   always_comb begin
      if (emit) begin
         res_valid_in = 1'b1;
      end else if (rsp_ready) begin
         res_valid_in = 1'b0;
      end else begin
         res_valid_in = res_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '0;
         fill_ff      <= '0;
         phase_ff     <= PH_SEARCH;
         res_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         res_byte_ff   <= res_byte_in;
         res_bvalid_ff <= res_bvalid_in;
         res_end_ff    <= res_end_in;
         res_status_ff <= res_status_in;
      end
   end

   assign rsp_valid      = res_valid_ff;
   assign rsp_value_byte = res_byte_ff;
   assign rsp_byte_valid = res_bvalid_ff;
   assign rsp_value_end  = res_end_ff;
   assign rsp_end_status = res_status_ff;

endmodule
`default_nettype wire

@@ hw/rtl/kvfe_checker.sv @@
// Port-level assertions for the extractor core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module kvfe_checker
   import kvfe_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_value_byte,
   input wire logic       rsp_byte_valid,
   input wire logic       rsp_value_end,
   input wire logic [1:0] rsp_end_status
);

   // stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value_byte) && $stable(rsp_end_status))
   // a full, stalled result register takes no new item
   `ASSERT_IMPLIES(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   // items without a value byte are end reports with zero data
   `ASSERT_IMPLIES(a_empty_is_end, clock, reset, rsp_valid && !rsp_byte_valid, rsp_value_end && rsp_value_byte == 8'd0 && rsp_end_status != ST_NONE)
   // mid-value items carry a byte and no status
   `ASSERT_IMPLIES(a_mid_value, clock, reset, rsp_valid && !rsp_value_end, rsp_byte_valid && rsp_end_status == ST_NONE)
   // a byte with an end can only be a cut-short value
   `ASSERT_IMPLIES(a_byte_end, clock, reset, rsp_valid && rsp_byte_valid && rsp_value_end, rsp_end_status == ST_CUT)

endmodule

bind key_value_field_extractor_core kvfe_checker u_kvfe_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_value_byte (rsp_value_byte),
   .rsp_byte_valid (rsp_byte_valid),
   .rsp_value_end  (rsp_value_end),
   .rsp_end_status (rsp_end_status)
);
`default_nettype wire
